// ===== rtl/core/arc_pkg.sv =====
// Package: shared types, S-box, lane 0 round constants and round functions.
`default_nettype none
package arc_pkg;

  typedef logic [15:0][7:0]  lane_t;
  typedef lane_t [15:0]      lanes_t;
  typedef logic [15:0][63:0] block_t;

  // One block handed from the front end to the round engine
  typedef struct packed {
    logic   fin;
    block_t blk;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_EMIT
  } back_state_t;

  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  FIN_MARK = 8'h01;
  localparam int          LC_DEPTH = 24;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] LANE0_CONST [LC_DEPTH][16] = '{
    '{8'h24,8'h3f,8'h6a,8'h88,8'h85,8'ha3,8'h08,8'hd3,8'h13,8'h19,8'h8a,8'h2e,8'h03,8'h70,8'h73,8'h44},
    '{8'h49,8'h7f,8'hd5,8'h11,8'h0b,8'h46,8'h10,8'ha7,8'h26,8'h32,8'h15,8'h5d,8'h06,8'he1,8'he7,8'h88},
    '{8'h92,8'hff,8'hab,8'h22,8'h16,8'h8c,8'h20,8'h4e,8'h4d,8'h65,8'h2a,8'hba,8'h0c,8'hc2,8'hce,8'h11},
    '{8'h25,8'hfe,8'h56,8'h45,8'h2c,8'h19,8'h41,8'h9c,8'h9a,8'hcb,8'h55,8'h74,8'h18,8'h85,8'h9d,8'h22},
    '{8'h4b,8'hfc,8'hac,8'h8a,8'h59,8'h32,8'h82,8'h39,8'h35,8'h97,8'haa,8'he9,8'h30,8'h0b,8'h3b,8'h45},
    '{8'h96,8'hf8,8'h58,8'h15,8'hb2,8'h65,8'h05,8'h73,8'h6b,8'h2f,8'h54,8'hd2,8'h61,8'h16,8'h77,8'h8a},
    '{8'h2d,8'hf0,8'hb0,8'h2a,8'h64,8'hcb,8'h0a,8'he7,8'hd7,8'h5f,8'ha8,8'ha5,8'hc3,8'h2c,8'hef,8'h15},
    '{8'h5b,8'he0,8'h60,8'h55,8'hc9,8'h97,8'h14,8'hce,8'haf,8'hbe,8'h50,8'h4a,8'h87,8'h59,8'hde,8'h2a},
    '{8'hb6,8'hc0,8'hc1,8'haa,8'h93,8'h2f,8'h28,8'h9d,8'h5e,8'h7c,8'ha0,8'h94,8'h0f,8'hb2,8'hbd,8'h55},
    '{8'h6c,8'h81,8'h83,8'h54,8'h27,8'h5f,8'h51,8'h3b,8'hbc,8'hf9,8'h40,8'h29,8'h1e,8'h64,8'h7a,8'haa},
    '{8'hd9,8'h03,8'h07,8'ha8,8'h4f,8'hbe,8'ha2,8'h77,8'h78,8'hf2,8'h80,8'h53,8'h3c,8'hc9,8'hf5,8'h54},
    '{8'hb3,8'h06,8'h0e,8'h50,8'h9e,8'h7c,8'h44,8'hef,8'hf1,8'he4,8'h01,8'ha6,8'h79,8'h93,8'hea,8'ha8},
    '{8'h66,8'h0c,8'h1c,8'ha0,8'h3d,8'hf9,8'h88,8'hde,8'he2,8'hc8,8'h02,8'h4c,8'hf3,8'h27,8'hd4,8'h50},
    '{8'hcd,8'h18,8'h38,8'h40,8'h7b,8'hf2,8'h11,8'hbd,8'hc4,8'h91,8'h04,8'h98,8'he6,8'h4f,8'ha9,8'ha0},
    '{8'h9b,8'h30,8'h71,8'h80,8'hf7,8'he4,8'h22,8'h7a,8'h89,8'h23,8'h08,8'h31,8'hcc,8'h9e,8'h52,8'h40},
    '{8'h37,8'h61,8'he3,8'h01,8'hee,8'hc8,8'h45,8'hf5,8'h13,8'h47,8'h10,8'h63,8'h99,8'h3d,8'ha4,8'h80},
    '{8'h6f,8'hc3,8'hc6,8'h02,8'hdc,8'h91,8'h8a,8'hea,8'h26,8'h8e,8'h20,8'hc7,8'h33,8'h7b,8'h48,8'h01},
    '{8'hdf,8'h87,8'h8d,8'h04,8'hb9,8'h23,8'h15,8'hd4,8'h4d,8'h1d,8'h41,8'h8f,8'h67,8'hf7,8'h90,8'h02},
    '{8'hbf,8'h0f,8'h1b,8'h08,8'h72,8'h47,8'h2a,8'ha9,8'h9a,8'h3a,8'h82,8'h1f,8'hcf,8'hee,8'h21,8'h04},
    '{8'h7e,8'h1e,8'h36,8'h10,8'he5,8'h8e,8'h55,8'h52,8'h35,8'h75,8'h05,8'h3e,8'h9f,8'hdc,8'h43,8'h08},
    '{8'hfd,8'h3c,8'h6d,8'h20,8'hca,8'h1d,8'haa,8'ha4,8'h6b,8'heb,8'h0a,8'h7d,8'h3f,8'hb9,8'h86,8'h10},
    '{8'hfa,8'h79,8'hdb,8'h41,8'h95,8'h3a,8'h54,8'h48,8'hd7,8'hd6,8'h14,8'hfb,8'h7f,8'h72,8'h0d,8'h20},
    '{8'hf4,8'hf3,8'hb7,8'h82,8'h2b,8'h75,8'ha8,8'h90,8'haf,8'had,8'h28,8'hf6,8'hff,8'he5,8'h1a,8'h41},
    '{8'he8,8'he6,8'h6e,8'h05,8'h57,8'heb,8'h50,8'h21,8'h5e,8'h5a,8'h51,8'hec,8'hfe,8'hca,8'h34,8'h82}
  };

  // GF(2^8) multiply by x
  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // AddRoundKey, SubBytes, ShiftRows, MixColumns; byte i is row i%4, column i/4
  function automatic lane_t aes_round(input lane_t v, input lane_t k);
    lane_t t;
    lane_t s;
    lane_t o;
    for (int i = 0; i < 16; i++) t[i] = v[i] ^ k[i];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[r + 4 * c] = SBOX[t[r + 4 * ((c + r) & 3)]];
    for (int c = 0; c < 4; c++) begin
      o[4*c]   = xt(s[4*c]) ^ xt(s[4*c+1]) ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
      o[4*c+1] = s[4*c] ^ xt(s[4*c+1]) ^ xt(s[4*c+2]) ^ s[4*c+2] ^ s[4*c+3];
      o[4*c+2] = s[4*c] ^ s[4*c+1] ^ xt(s[4*c+2]) ^ xt(s[4*c+3]) ^ s[4*c+3];
      o[4*c+3] = xt(s[4*c]) ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ xt(s[4*c+3]);
    end
    return o;
  endfunction

  // Zip mixing at 1, 2, 4 and 8 byte granularity across lane pairs
  function automatic lanes_t zip_all(input lanes_t l);
    lanes_t w;
    lane_t  lo;
    lane_t  hi;
    int     d;
    int     h;
    w = l;
    for (int sh = 0; sh < 4; sh++) begin
      d = 1 << sh;
      h = 8 >> sh;   // elements per lane half
      for (int j = 0; j < 16; j++) begin
        if ((j & d) == 0) begin
          for (int k = 0; k < h; k++)
            for (int x = 0; x < d; x++) begin
              lo[(2*k)*d + x]   = w[j][k*d + x];
              lo[(2*k+1)*d + x] = w[j+d][k*d + x];
              hi[(2*k)*d + x]   = w[j][(h + k)*d + x];
              hi[(2*k+1)*d + x] = w[j+d][(h + k)*d + x];
            end
          w[j]   = lo;
          w[j+d] = hi;
        end
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/arc_if.sv =====
// Interfaces: message word channel and digest word channel.
`default_nettype none
interface arc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [6:0]  valid_bits;
  logic        last_word;
  modport source(output valid, msg_word, valid_bits, last_word, input ready);
  modport sink(input valid, msg_word, valid_bits, last_word, output ready);
endinterface

interface arc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source(output valid, digest_word, digest_last, input ready);
  modport sink(input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/arc_front.sv =====
// Front end: collects message words into blocks and applies padding.
`default_nettype none
module arc_front (
  input  logic          clk,
  input  logic          rst_n,
  arc_in_if.sink        in_ch,
  output arc_pkg::job_t push_job,
  output logic          push_valid,
  input  logic          push_ready
);
  import arc_pkg::*;

  block_t      buf_r;
  logic [3:0]  pos_r;
  logic        pend_r;
  logic        accept;
  logic        full_v;
  logic [5:0]  vb;
  logic [63:0] mask;
  logic [63:0] part_word;
  block_t      blk;

  assign in_ch.ready = push_ready && !pend_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full_v      = in_ch.valid_bits[6];
  assign vb          = in_ch.valid_bits[5:0];

  // tail word: keep valid bits, pad bit right after
  assign mask      = ~64'h0 << (7'd64 - {1'b0, vb});
  assign part_word = (in_ch.msg_word & mask) | (64'h1 << (6'd63 - vb));

  // block as it stands with the current word in place
  always_comb begin
    for (int s = 0; s < 16; s++) begin
      if (5'(s) < {1'b0, pos_r})
        blk[s] = buf_r[s];
      else if (5'(s) == {1'b0, pos_r})
        blk[s] = (in_ch.last_word && !full_v) ? part_word : in_ch.msg_word;
      else if (5'(s) == {1'b0, pos_r} + 5'd1 && in_ch.last_word && full_v)
        blk[s] = PAD_WORD;
      else
        blk[s] = '0;
    end
  end

  // hand blocks over; a full last word that fills a block adds a pad block
  always_comb begin
    push_valid = pend_r || (accept && (in_ch.last_word || pos_r == 4'd15));
    if (pend_r) begin
      push_job.fin    = 1'b1;
      push_job.blk    = '0;
      push_job.blk[0] = PAD_WORD;
    end else begin
      push_job.fin = in_ch.last_word && !(full_v && pos_r == 4'd15);
      push_job.blk = blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      if (pend_r && push_ready) pend_r <= 1'b0;
      if (accept) begin
        pos_r  <= (in_ch.last_word || pos_r == 4'd15) ? 4'd0 : pos_r + 4'd1;
        pend_r <= in_ch.last_word && full_v && pos_r == 4'd15;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) buf_r[pos_r] <= in_ch.msg_word;
  end

endmodule
`default_nettype wire

// ===== rtl/core/arc_queue.sv =====
// Two-entry block queue between front end and round engine.
`default_nettype none
module arc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  arc_pkg::job_t wr_job,
  input  logic          wr_valid,
  output logic          wr_ready,
  output arc_pkg::job_t rd_job,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import arc_pkg::*;

  job_t       mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       wr_en;
  logic       rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job   = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

// ===== rtl/core/arc_back.sv =====
// Round engine: absorbs blocks one AES round per cycle and emits digests.
`default_nettype none
module arc_back #(
  parameter int STEPS = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  arc_pkg::job_t pop_job,
  input  logic          pop_valid,
  output logic          pop_ready,
  arc_out_if.source     out_ch
);
  import arc_pkg::*;

  localparam int ROUNDS = 2 * STEPS;
  localparam int RW     = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;

  back_state_t      state_r, state_nxt;
  lanes_t           lanes_r;
  lanes_t           rl;
  lanes_t           key;
  block_t           blk_r;
  logic             fin_r;
  lane_t [7:0]      ff_r;
  logic [63:0]      cnt_r;
  logic [RW-1:0]    rnd_r;
  logic [3:0]       idx_r;
  logic             phase;
  logic             first_step;
  logic             last_rnd;
  logic             out_acc;
  logic [4:0]       ci;

  assign phase      = rnd_r[0];
  assign first_step = (rnd_r >> 1) == '0;
  assign last_rnd   = rnd_r == RW'(ROUNDS - 1);
  assign out_acc    = out_ch.valid && out_ch.ready;
  assign ci         = 5'(rnd_r);

  // injected words for this round
  always_comb begin
    key = '0;
    if (!phase) begin
      if (first_step)
        for (int j = 0; j < 8; j++)
          for (int b = 0; b < 16; b++)
            key[j][b] = blk_r[2*j + b/8][63 - 8*(b%8) -: 8];
      for (int b = 0; b < 8; b++) key[8][b] = cnt_r[8*b +: 8];
      if (first_step && fin_r) key[15][15] = FIN_MARK;
    end
  end

  // one round on all lanes, plus zip and feedforward where due
  always_comb begin
    for (int j = 0; j < 16; j++) rl[j] = aes_round(lanes_r[j], key[j]);
    for (int b = 0; b < 16; b++) rl[0][b] = rl[0][b] ^ LANE0_CONST[ci][b];
    if (phase) rl = zip_all(rl);
    if (last_rnd) begin
      for (int j = 0; j < 8; j++) rl[8+j] = rl[8+j] ^ ff_r[j];
      if (fin_r) rl[15][15] = rl[15][15] ^ FIN_MARK;
    end
  end

  // digest word from lanes 8..15
  always_comb begin
    out_ch.valid       = state_r == B_EMIT;
    out_ch.digest_last = idx_r == 4'd15;
    for (int q = 0; q < 8; q++)
      out_ch.digest_word[63 - 8*q -: 8] = lanes_r[{1'b1, idx_r[3:1]}][{idx_r[0], 3'(q)}];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    case (state_r)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) state_nxt = B_ROUND;
      end
      B_ROUND: begin
        if (last_rnd) state_nxt = fin_r ? B_EMIT : B_IDLE;
      end
      B_EMIT: begin
        if (out_acc && idx_r == 4'd15) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      lanes_r <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            fin_r <= pop_job.fin;
            rnd_r <= '0;
          end
        end
        B_ROUND: begin
          lanes_r <= rl;
          rnd_r   <= rnd_r + RW'(1);
          if (last_rnd && !fin_r) cnt_r <= cnt_r + 64'd1;
          idx_r   <= '0;
        end
        B_EMIT: begin
          if (out_acc) begin
            idx_r <= idx_r + 4'd1;
            if (idx_r == 4'd15) begin
              lanes_r <= '0;
              cnt_r   <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // block and feedforward copy captured at job start
  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      blk_r <= pop_job.blk;
      ff_r  <= lanes_r[15:8];
    end
  end

`ifndef ASSERT_OFF
  a_emit_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> fin_r) else $error("digest without final block");
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ROUND |-> rnd_r <= RW'(ROUNDS - 1)) else $error("round index out of range");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && idx_r == 4'd15) |=> (cnt_r == '0 && state_r == B_IDLE))
    else $error("state not cleared after digest");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ROUND || state_r == B_EMIT) |-> !pop_ready)
    else $error("block taken while busy");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/aes_round_sponge_hash_1024_core.sv =====
// Top level: AES-round sponge hash with 1024-bit digest.
//
//  channel  dir  payload                             transaction
//  in_ch    in   msg_word, valid_bits, last_word     one message word
//  out_ch   out  digest_word, digest_last            one digest word
//
// The engine loads a block, then runs 2*STEPS rounds, one AES round on all
// sixteen lanes per cycle; words are taken one per cycle while in_ch.ready is high.
// A last word yields 16 digest words, one per cycle while out_ch is ready.
// Reset (rst_n low, synchronous) zeroes lanes, counter and control.
// A two-block queue lets input continue while the engine runs or waits on out_ch.
`default_nettype none
module aes_round_sponge_hash_1024_core #(
  parameter int STEPS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  arc_in_if.sink    in_ch,
  arc_out_if.source out_ch
);
  import arc_pkg::*;

  job_t push_job;
  logic push_valid;
  logic push_ready;
  job_t pop_job;
  logic pop_valid;
  logic pop_ready;

  arc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push_job(push_job), .push_valid(push_valid), .push_ready(push_ready)
  );

  arc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_job(push_job), .wr_valid(push_valid), .wr_ready(push_ready),
    .rd_job(pop_job), .rd_valid(pop_valid), .rd_ready(pop_ready)
  );

  arc_back #(.STEPS(STEPS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .pop_job(pop_job), .pop_valid(pop_valid), .pop_ready(pop_ready),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// ===== tb/sv/aes_round_sponge_hash_1024_core_tb.sv =====
// Testbench for the AES-round sponge hash core: scoreboard, stimulus and digest checks.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: software copy of the hash state and the queue of pending digest words
class digest_scoreboard;
  typedef logic [15:0][7:0] lane_bytes_t;

  lane_bytes_t   lanes [16];
  logic [63:0]   msg_buf [16];
  int unsigned   word_pos;
  logic [63:0]   blocks_done;
  logic [64:0]   pending_digest [$];
  int unsigned   errors;

  function new();
    clear_state();
    errors = 0;
  endfunction

  function void clear_state();
    for (int j = 0; j < 16; j++) lanes[j] = '0;
    word_pos = 0;
    blocks_done = '0;
  endfunction

  static function logic [7:0] gmul2(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  static function lane_bytes_t one_round(lane_bytes_t v, lane_bytes_t k);
    lane_bytes_t t, s, o;
    logic [7:0] a0, a1, a2, a3;
    for (int i = 0; i < 16; i++) t[i] = v[i] ^ k[i];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[r + 4 * c] = arc_pkg::SBOX[t[r + 4 * ((c + r) % 4)]];
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      o[4*c]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
      o[4*c+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
      o[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
      o[4*c+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
    end
    return o;
  endfunction

  // interleave d-byte elements of lanes a and b
  function void interleave(int a, int b, int d);
    lane_bytes_t lo, hi;
    int n;
    n = 16 / d;
    for (int k = 0; k < n / 2; k++)
      for (int x = 0; x < d; x++) begin
        lo[(2*k)*d + x]   = lanes[a][k*d + x];
        lo[(2*k+1)*d + x] = lanes[b][k*d + x];
        hi[(2*k)*d + x]   = lanes[a][(n/2 + k)*d + x];
        hi[(2*k+1)*d + x] = lanes[b][(n/2 + k)*d + x];
      end
    lanes[a] = lo;
    lanes[b] = hi;
  endfunction

  function void compress_block(logic [63:0] counter, bit fin);
    lane_bytes_t blk [8];
    lane_bytes_t ctr, fin_mark, key, saved [8];
    for (int i = 0; i < 128; i++) blk[i / 16][i % 16] = msg_buf[i / 8][63 - 8 * (i % 8) -: 8];
    ctr = '0;
    for (int i = 0; i < 8; i++) ctr[i] = counter[8*i +: 8];
    fin_mark = '0;
    fin_mark[15] = arc_pkg::FIN_MARK;
    for (int j = 0; j < 8; j++) saved[j] = lanes[8 + j];
    for (int st = 0; st < 12; st++) begin
      for (int j = 0; j < 16; j++) begin
        key = '0;
        if (st == 0 && j < 8) key = blk[j];
        else if (j == 8) key = ctr;
        else if (j == 15 && st == 0 && fin) key = fin_mark;
        lanes[j] = one_round(lanes[j], key);
      end
      for (int i = 0; i < 16; i++) lanes[0][i] ^= arc_pkg::LANE0_CONST[(2 * st) % 24][i];
      for (int j = 0; j < 16; j++) lanes[j] = one_round(lanes[j], '0);
      for (int i = 0; i < 16; i++) lanes[0][i] ^= arc_pkg::LANE0_CONST[(2 * st + 1) % 24][i];
      for (int d = 1; d <= 8; d = d * 2)
        for (int j = 0; j < 16; j++)
          if ((j & d) == 0) interleave(j, j + d, d);
    end
    for (int j = 0; j < 8; j++) lanes[8 + j] ^= saved[j];
    if (fin) lanes[15][15] ^= arc_pkg::FIN_MARK;
  endfunction

  function void take_word(logic [63:0] w);
    msg_buf[word_pos] = w;
    word_pos++;
    if (word_pos == 16) begin
      compress_block(blocks_done, 1'b0);
      blocks_done++;
      word_pos = 0;
    end
  endfunction

  // note one accepted input transaction
  function void note_input(logic [63:0] w, logic [6:0] nbits, logic last);
    int unsigned v;
    logic [63:0] mask, dw;
    if (!last) begin
      take_word(w);
      return;
    end
    v = (nbits > 64) ? 64 : nbits;
    if (v == 64) begin
      take_word(w);
      msg_buf[word_pos] = arc_pkg::PAD_WORD;
    end else begin
      mask = (v == 0) ? 64'd0 : (~64'd0 << (64 - v));
      msg_buf[word_pos] = (w & mask) | (64'd1 << (63 - v));
    end
    for (int i = word_pos + 1; i < 16; i++) msg_buf[i] = '0;
    compress_block(blocks_done, 1'b1);
    for (int k = 0; k < 16; k++) begin
      dw = '0;
      for (int i = 0; i < 8; i++) dw = {dw[55:0], lanes[8 + k / 2][(k % 2) * 8 + i]};
      pending_digest.push_back({dw, k == 15});
    end
    clear_state();
  endfunction

  // check one accepted digest transaction
  function void check_output(logic [63:0] w, logic last);
    logic [64:0] exp_item;
    if (pending_digest.size() == 0) begin
      $error("unexpected digest word %h", w);
      errors++;
      return;
    end
    exp_item = pending_digest.pop_front();
    if (w !== exp_item[64:1]) begin
      $error("digest_word expected %h actual %h", exp_item[64:1], w);
      errors++;
    end
    if (last !== exp_item[0]) begin
      $error("digest_last expected %b actual %b", exp_item[0], last);
      errors++;
    end
  endfunction
endclass

module aes_round_sponge_hash_1024_core_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  arc_in_if  in_ch();
  arc_out_if out_ch();

  aes_round_sponge_hash_1024_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  digest_scoreboard sb = new();
  bit stall_mode;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.msg_word = '0;
    in_ch.valid_bits = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
  end

  // receiver stall pattern: random ready in stall mode (6 in 10 high), else always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_mode) begin
      out_ch.ready <= ($urandom_range(0, 9) < 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // scoreboard sampling on accepted transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.msg_word, in_ch.valid_bits, in_ch.last_word);
      if (out_ch.valid && out_ch.ready)
        sb.check_output(out_ch.digest_word, out_ch.digest_last);
    end
  end

  int unsigned burst_left;
  int sent;

  // send one message word, with random gaps between bursts
  task automatic send_word(logic [63:0] w, logic [6:0] nbits, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sent++;
    in_ch.valid <= 1'b1;
    in_ch.msg_word <= w;
    in_ch.valid_bits <= nbits;
    in_ch.last_word <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // message of n ordinary words then a last word with given valid bit count
  task automatic send_message(int n, logic [6:0] tail_bits, logic [63:0] fill);
    for (int i = 0; i < n; i++)
      send_word(fill == 64'd1 ? rand64() : fill, $urandom_range(0, 127), 1'b0);
    send_word(fill == 64'd1 ? rand64() : fill, tail_bits, 1'b1);
  endtask

  int n;
  logic [6:0] tb;

  initial begin
    burst_left = 0;
    sent = 0;
    stall_mode = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tail, full tail, extreme words, oversize count, block edges
    send_message(0, 7'd0, 64'd0);
    send_message(0, 7'd64, {64{1'b1}});
    send_message(0, 7'd127, 64'd0);
    send_message(0, 7'd63, {64{1'b1}});
    send_message(15, 7'd64, {64{1'b1}});
    send_message(15, 7'd1, 64'd1);
    send_message(16, 7'd32, 64'd1);
    stall_mode = 1'b1;

    // random messages, mostly short, some across block boundaries
    while (sent < 110) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 34) : $urandom_range(0, 8);
      case ($urandom_range(0, 3))
        0: tb = 7'd64;
        1: tb = $urandom_range(65, 127);
        default: tb = $urandom_range(0, 63);
      endcase
      send_message(n, tb, 64'd1);
      if ($urandom_range(0, 3) == 0) stall_mode = ~stall_mode;
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_digest.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("aes_round_sponge_hash_1024_core test passed");
    end else begin
      $display("aes_round_sponge_hash_1024_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("aes_round_sponge_hash_1024_core test failed");
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/arc_pkg.sv
rtl/core/arc_if.sv
rtl/core/arc_front.sv
rtl/core/arc_queue.sv
rtl/core/arc_back.sv
rtl/core/aes_round_sponge_hash_1024_core.sv
tb/sv/aes_round_sponge_hash_1024_core_tb.sv
